// File: rtl/core/rave_pkg.sv
// ============================================================================
// rave_pkg
// Shared types and constants of the ray arrow vertex expander.
// ============================================================================
package rave_pkg;

   localparam int VERTICES_PER_RAY = 7;
   localparam int FRAC_BITS        = 16;

   // configuration port
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_X     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_Y     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_Z     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THICKNESS = 2'd3;

   localparam int THICK_W = 31;
   localparam logic [THICK_W-1:0] THICK_RESET = 31'd6554;

   // distance scale, clamped to [1, 1.5]
   localparam int SCALE_W = FRAC_BITS + 1;
   localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1 << FRAC_BITS);
   localparam logic [SCALE_W-1:0] SCALE_LIM = SCALE_W'(3 << (FRAC_BITS - 1));
   localparam logic [32:0]        MAG_LIM   = 33'(3 << (FRAC_BITS - 1));

   localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

   // vertex numbering
   localparam int VTX_W = 3;
   localparam logic [VTX_W-1:0] VTX_QUAD0  = 3'd0;
   localparam logic [VTX_W-1:0] VTX_QUAD1  = 3'd1;
   localparam logic [VTX_W-1:0] VTX_QUAD2  = 3'd2;
   localparam logic [VTX_W-1:0] VTX_QUAD3  = 3'd3;
   localparam logic [VTX_W-1:0] VTX_HEAD_L = 3'd4;
   localparam logic [VTX_W-1:0] VTX_TIP    = 3'd5;
   localparam logic [VTX_W-1:0] VTX_HEAD_R = 3'd6;
   localparam logic [VTX_W-1:0] VTX_LAST   = VTX_W'(VERTICES_PER_RAY - 1);

   typedef logic signed [31:0] coord_type;
   typedef logic signed [32:0] side_type;
   typedef logic signed [33:0] tip_type;

   // classified request, front to back
   typedef struct packed {
      coord_type [2:0] org;
      coord_type [2:0] dir;
      coord_type [2:0] fwd;
      logic [31:0]     color;
      logic            last;
      logic            big;
   } ray_type;

   // finished arrow geometry, back to emitter
   typedef struct packed {
      coord_type [2:0] org;
      coord_type [2:0] dir;
      side_type  [2:0] side;
      tip_type   [2:0] tip;
      logic [31:0]     color;
      logic            last;
   } arrow_type;

endpackage

// File: rtl/core/rave_front.sv
// ============================================================================
// rave_front
// Request stage: takes a ray, forms camera minus origin and classifies it.
// ============================================================================
module rave_front (
   input  logic                  clock,
   input  logic                  reset,
   input  rave_pkg::coord_type [2:0] cam,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rave_pkg::coord_type [2:0] org,
   input  rave_pkg::coord_type [2:0] dir,
   input  logic [31:0]           color,
   input  logic                  last,
   output logic                  push_valid,
   input  logic                  push_full,
   output rave_pkg::ray_type     push_data
);
   import rave_pkg::*;

   logic              valid_ff, valid_in;
   ray_type           ray_ff, ray_in;
   logic signed [32:0] fw [3];
   logic [32:0]       fw_mag [3];
   logic              wide;
   logic              big;
   logic              open_slot;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fw[i]     = 33'($signed(cam[i])) - 33'($signed(org[i]));
         fw_mag[i] = fw[i][32] ? 33'(33'd0 - fw[i]) : fw[i];
      end
      wide = (fw[0][32] != fw[0][31]) || (fw[1][32] != fw[1][31]) ||
             (fw[2][32] != fw[2][31]);
      big  = (fw_mag[0] >= MAG_LIM) || (fw_mag[1] >= MAG_LIM) || (fw_mag[2] >= MAG_LIM);
   end

   assign open_slot = !valid_ff || !push_full;
   assign req_stall = !open_slot;

   always_comb begin
      ray_in   = ray_ff;
      valid_in = valid_ff;
      if (open_slot) begin
         valid_in = req_valid;
         ray_in.org   = org;
         ray_in.dir   = dir;
         ray_in.color = color;
         ray_in.last  = last;
         ray_in.big   = big;
         for (int i = 0; i < 3; i++) begin
            // halve a wide offset so the cross product keeps its direction
            ray_in.fwd[i] = wide ? fw[i][32:1] : fw[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ray_ff <= ray_in;
   end

   assign push_valid = valid_ff;
   assign push_data  = ray_ff;

endmodule

// File: rtl/core/rave_queue.sv
// ============================================================================
// rave_queue
// Two-entry request queue between the front stage and the arithmetic back.
// ============================================================================
module rave_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_full,
   input  rave_pkg::ray_type push_data,
   input  logic              pop,
   output logic              pop_valid,
   output rave_pkg::ray_type pop_data
);
   import rave_pkg::*;

   localparam int DEPTH = 2;

   ray_type    slot_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign push_full = (count_ff == 2'(DEPTH));
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/rave_engine.sv
// ============================================================================
// rave_engine
// Arithmetic back: scale, gains, cross product, unit vectors via a shared
// multiplier, a bit-serial square root and three restoring divider lanes.
// ============================================================================
module rave_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rave_pkg::THICK_W-1:0] thickness,
   input  logic                         q_valid,
   input  rave_pkg::ray_type            q_data,
   output logic                         q_pop,
   output logic                         out_valid,
   input  logic                         out_stall,
   output rave_pkg::arrow_type          out_data
);
   import rave_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FSQ   = 4'd1;
   localparam logic [3:0] S_SQS   = 4'd2;
   localparam logic [3:0] S_K     = 4'd3;
   localparam logic [3:0] S_K2    = 4'd4;
   localparam logic [3:0] S_CROSS = 4'd5;
   localparam logic [3:0] S_ABS   = 4'd6;
   localparam logic [3:0] S_NORM  = 4'd7;
   localparam logic [3:0] S_MSQ   = 4'd8;
   localparam logic [3:0] S_SQL   = 4'd9;
   localparam logic [3:0] S_MGAIN = 4'd10;
   localparam logic [3:0] S_DIV   = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;

   logic [3:0]         state_ff, state_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               vsel_ff, vsel_in;
   ray_type            ray_ff, ray_in;
   logic [63:0]        acc_ff, acc_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [31:0]        k_ff, k_in;
   logic [32:0]        k2_ff, k2_in;
   logic signed [64:0] c_ff [3];
   logic signed [64:0] c_in [3];
   logic [63:0]        m_ff [3];
   logic [63:0]        m_in [3];
   logic [2:0]         neg_ff, neg_in;
   logic [63:0]        top_ff, top_in;
   logic [63:0]        sq_x_ff, sq_x_in;
   logic [33:0]        sq_rem_ff, sq_rem_in;
   logic [31:0]        sq_root_ff, sq_root_in;
   logic [32:0]        gain_ff, gain_in;
   logic [31:0]        dvs_ff, dvs_in;
   logic [31:0]        drem_ff [3];
   logic [31:0]        drem_in [3];
   logic [33:0]        dn_ff [3];
   logic [33:0]        dn_in [3];
   side_type [2:0]     side_ff, side_in;
   tip_type  [2:0]     tip_ff, tip_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic [1:0]         idx;
   logic [1:0]         fi, di;
   logic [35:0]        rem_sh, trial;
   logic               sq_ge;
   logic [33:0]        rem_new;
   logic [31:0]        root_new;
   logic [SCALE_W-1:0] scale_clamp;
   logic [63:0]        kround, k2round, num;
   logic [63:0]        abs_m [3];
   logic [2:0]         abs_n;
   logic [63:0]        abs_top;
   logic [32:0]        dt [3];
   logic [2:0]         dge;
   logic [33:0]        dq [3];

   function automatic logic [32:0] mag32(coord_type v);
      logic [32:0] w;
      w = {v[31], v};
      return w[32] ? 33'(33'd0 - w) : w;
   endfunction

   assign idx = cnt_ff[1:0];

   // operand pairs of the cross product, two products per component
   always_comb begin
      case (cnt_ff[2:0])
         3'd0: begin fi = 2'd1; di = 2'd2; end
         3'd1: begin fi = 2'd2; di = 2'd1; end
         3'd2: begin fi = 2'd2; di = 2'd0; end
         3'd3: begin fi = 2'd0; di = 2'd2; end
         3'd4: begin fi = 2'd0; di = 2'd1; end
         default: begin fi = 2'd1; di = 2'd0; end
      endcase
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_FSQ: begin
            mul_a = $signed({1'b0, mag32(ray_ff.fwd[idx])});
            mul_b = $signed({1'b0, mag32(ray_ff.fwd[idx])});
         end
         S_K: begin
            mul_a = $signed({3'b0, thickness});
            mul_b = $signed(34'(scale_ff));
         end
         S_K2: begin
            mul_a = $signed({2'b0, k_ff});
            mul_b = $signed({3'b0, SQRT3_Q30});
         end
         S_CROSS: begin
            mul_a = 34'($signed(ray_ff.fwd[fi]));
            mul_b = 34'($signed(ray_ff.dir[di]));
         end
         S_MSQ: begin
            mul_a = $signed({4'b0, m_ff[idx][29:0]});
            mul_b = $signed({4'b0, m_ff[idx][29:0]});
         end
         S_MGAIN: begin
            mul_a = $signed({4'b0, m_ff[idx][29:0]});
            mul_b = $signed({1'b0, gain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // one root bit per cycle
   always_comb begin
      rem_sh   = {sq_rem_ff, sq_x_ff[63:62]};
      trial    = {2'b0, sq_root_ff, 2'b01};
      sq_ge    = rem_sh >= trial;
      rem_new  = sq_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_new = {sq_root_ff[30:0], sq_ge};
      if (root_new < 32'(SCALE_ONE)) begin
         scale_clamp = SCALE_ONE;
      end else if (root_new > 32'(SCALE_LIM)) begin
         scale_clamp = SCALE_LIM;
      end else begin
         scale_clamp = root_new[SCALE_W-1:0];
      end
      kround  = mul_p[63:0] + (64'd1 << (FRAC_BITS - 1));
      k2round = mul_p[63:0] + (64'd1 << 29);
      num     = mul_p[63:0] + 64'(dvs_ff >> 1);
   end

   // magnitudes of the vector being normalised, and their maximum
   always_comb begin
      logic signed [64:0] src;
      logic signed [64:0] mg;
      abs_top = '0;
      for (int i = 0; i < 3; i++) begin
         src      = vsel_ff ? 65'($signed(ray_ff.dir[i])) : c_ff[i];
         mg       = src[64] ? 65'(65'sd0 - src) : src;
         abs_n[i] = src[64];
         abs_m[i] = mg[63:0];
         if (abs_m[i] > abs_top) begin
            abs_top = abs_m[i];
         end
      end
   end

   // divider lanes, one quotient bit per cycle
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dt[i]  = {drem_ff[i], dn_ff[i][33]};
         dge[i] = dt[i] >= {1'b0, dvs_ff};
         dq[i]  = {dn_ff[i][32:0], dge[i]};
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      vsel_in    = vsel_ff;
      ray_in     = ray_ff;
      acc_in     = acc_ff;
      scale_in   = scale_ff;
      k_in       = k_ff;
      k2_in      = k2_ff;
      c_in       = c_ff;
      m_in       = m_ff;
      neg_in     = neg_ff;
      top_in     = top_ff;
      sq_x_in    = sq_x_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      gain_in    = gain_ff;
      dvs_in     = dvs_ff;
      drem_in    = drem_ff;
      dn_in      = dn_ff;
      side_in    = side_ff;
      tip_in     = tip_ff;
      q_pop      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               ray_in  = q_data;
               cnt_in  = '0;
               vsel_in = 1'b0;
               acc_in  = '0;
               if (q_data.big) begin
                  scale_in = SCALE_LIM;
                  state_in = S_K;
               end else begin
                  state_in = S_FSQ;
               end
            end
         end
         S_FSQ, S_MSQ: begin
            acc_in = acc_ff + mul_p[63:0];
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               sq_x_in    = acc_ff + mul_p[63:0];
               sq_rem_in  = '0;
               sq_root_in = '0;
               cnt_in     = '0;
               state_in   = (state_ff == S_FSQ) ? S_SQS : S_SQL;
            end
         end
         S_SQS, S_SQL: begin
            sq_x_in    = sq_x_ff << 2;
            sq_rem_in  = rem_new;
            sq_root_in = root_new;
            cnt_in     = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               cnt_in = '0;
               if (state_ff == S_SQS) begin
                  scale_in = scale_clamp;
                  state_in = S_K;
               end else begin
                  gain_in  = vsel_ff ? k2_ff : {1'b0, k_ff};
                  dvs_in   = vsel_ff ? root_new : {root_new[30:0], 1'b0};
                  state_in = S_MGAIN;
               end
            end
         end
         S_K: begin
            k_in     = kround[FRAC_BITS+31:FRAC_BITS];
            state_in = S_K2;
         end
         S_K2: begin
            k2_in    = k2round[62:30];
            cnt_in   = '0;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            c_in[cnt_ff[2:1]] = cnt_ff[0] ? 65'(c_ff[cnt_ff[2:1]] - $signed(mul_p[64:0]))
                                          : $signed(mul_p[64:0]);
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd5) begin
               cnt_in   = '0;
               state_in = S_ABS;
            end
         end
         S_ABS: begin
            m_in     = abs_m;
            neg_in   = abs_n;
            top_in   = abs_top;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (top_ff == 64'd0) begin
               // a zero vector gives a zero offset
               if (!vsel_ff) begin
                  side_in  = '0;
                  vsel_in  = 1'b1;
                  state_in = S_ABS;
               end else begin
                  tip_in   = '0;
                  state_in = S_OUT;
               end
            end else if (top_ff[63:30] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
               top_in = top_ff >> 1;
            end else if (top_ff[63:29] == '0) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] << 1;
               end
               top_in = top_ff << 1;
            end else begin
               acc_in   = '0;
               cnt_in   = '0;
               state_in = S_MSQ;
            end
         end
         S_MGAIN: begin
            drem_in[idx] = 32'(num[63:34]);
            dn_in[idx]   = num[33:0];
            cnt_in       = cnt_ff + 6'd1;
            if (cnt_ff == 6'd2) begin
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            for (int i = 0; i < 3; i++) begin
               drem_in[i] = dge[i] ? 32'(dt[i] - {1'b0, dvs_ff}) : dt[i][31:0];
               dn_in[i]   = dq[i];
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd33) begin
               cnt_in = '0;
               if (!vsel_ff) begin
                  for (int i = 0; i < 3; i++) begin
                     side_in[i] = neg_ff[i] ? 33'(33'sd0 - $signed({1'b0, dq[i][31:0]}))
                                            : $signed({1'b0, dq[i][31:0]});
                  end
                  vsel_in  = 1'b1;
                  state_in = S_ABS;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     tip_in[i] = neg_ff[i] ? 34'(34'sd0 - $signed({1'b0, dq[i][32:0]}))
                                           : $signed({1'b0, dq[i][32:0]});
                  end
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!out_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         vsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vsel_ff  <= vsel_in;
      end
      ray_ff     <= ray_in;
      acc_ff     <= acc_in;
      scale_ff   <= scale_in;
      k_ff       <= k_in;
      k2_ff      <= k2_in;
      c_ff       <= c_in;
      m_ff       <= m_in;
      neg_ff     <= neg_in;
      top_ff     <= top_in;
      sq_x_ff    <= sq_x_in;
      sq_rem_ff  <= sq_rem_in;
      sq_root_ff <= sq_root_in;
      gain_ff    <= gain_in;
      dvs_ff     <= dvs_in;
      drem_ff    <= drem_in;
      dn_ff      <= dn_in;
      side_ff    <= side_in;
      tip_ff     <= tip_in;
   end

   assign out_valid      = (state_ff == S_OUT);
   assign out_data.org   = ray_ff.org;
   assign out_data.dir   = ray_ff.dir;
   assign out_data.side  = side_ff;
   assign out_data.tip   = tip_ff;
   assign out_data.color = ray_ff.color;
   assign out_data.last  = ray_ff.last;

endmodule

// File: rtl/core/rave_emit.sv
// ============================================================================
// rave_emit
// Vertex emitter: holds one arrow and sends its seven vertices, saturated.
// ============================================================================
module rave_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_stall,
   input  rave_pkg::arrow_type            in_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rave_pkg::VTX_W-1:0]     rsp_vertex_index,
   output rave_pkg::coord_type            rsp_pos_x,
   output rave_pkg::coord_type            rsp_pos_y,
   output rave_pkg::coord_type            rsp_pos_z,
   output logic [31:0]                    rsp_vertex_color,
   output logic                           rsp_last_vertex,
   output logic                           rsp_frame_end
);
   import rave_pkg::*;

   localparam logic signed [35:0] POS_MAX = 36'sd2147483647;
   localparam logic signed [35:0] POS_MIN = -36'sd2147483648;

   arrow_type         hold_ff, hold_in;
   logic              hold_valid_ff, hold_valid_in;
   logic [VTX_W-1:0]  vidx_ff, vidx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [VTX_W-1:0]  rsp_vertex_index_ff;
   coord_type [2:0]   rsp_pos_ff, rsp_pos_in;
   logic [31:0]       rsp_vertex_color_ff;
   logic              rsp_last_vertex_ff;
   logic              rsp_frame_end_ff;
   logic              out_free;
   logic              load;
   logic              last_load;
   logic              take;
   logic signed [35:0] base [3];
   logic signed [35:0] pos [3];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = hold_valid_ff && out_free;
   assign last_load = load && (vidx_ff == VTX_LAST);
   assign in_stall  = hold_valid_ff && !last_load;
   assign take      = in_valid && !in_stall;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         base[i] = 36'($signed(hold_ff.org[i]));
         case (vidx_ff)
            VTX_QUAD0: pos[i] = base[i] - 36'($signed(hold_ff.side[i]));
            VTX_QUAD1: pos[i] = base[i] + 36'($signed(hold_ff.side[i]));
            VTX_QUAD2: pos[i] = base[i] + 36'($signed(hold_ff.dir[i]))
                                + 36'($signed(hold_ff.side[i]));
            VTX_QUAD3: pos[i] = base[i] + 36'($signed(hold_ff.dir[i]))
                                - 36'($signed(hold_ff.side[i]));
            VTX_HEAD_L: pos[i] = base[i] + 36'($signed(hold_ff.dir[i]))
                                 + (36'($signed(hold_ff.side[i])) <<< 1);
            VTX_TIP: pos[i] = base[i] + 36'($signed(hold_ff.dir[i]))
                              + 36'($signed(hold_ff.tip[i]));
            VTX_HEAD_R: pos[i] = base[i] + 36'($signed(hold_ff.dir[i]))
                                 - (36'($signed(hold_ff.side[i])) <<< 1);
            default: pos[i] = base[i];
         endcase
         if (pos[i] > POS_MAX) begin
            rsp_pos_in[i] = POS_MAX[31:0];
         end else if (pos[i] < POS_MIN) begin
            rsp_pos_in[i] = POS_MIN[31:0];
         end else begin
            rsp_pos_in[i] = pos[i][31:0];
         end
      end
   end

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      vidx_in       = vidx_ff;
      if (load) begin
         vidx_in = vidx_ff + 3'd1;
      end
      if (last_load) begin
         hold_valid_in = 1'b0;
      end
      if (take) begin
         hold_in       = in_data;
         hold_valid_in = 1'b1;
         vidx_in       = VTX_QUAD0;
      end
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         vidx_ff       <= VTX_QUAD0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         vidx_ff       <= vidx_in;
      end
      hold_ff <= hold_in;
      if (load) begin
         rsp_vertex_index_ff <= vidx_ff;
         rsp_pos_ff          <= rsp_pos_in;
         rsp_vertex_color_ff <= hold_ff.color;
         rsp_last_vertex_ff  <= (vidx_ff == VTX_LAST);
         rsp_frame_end_ff    <= (vidx_ff == VTX_LAST) && hold_ff.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_vertex_index_ff;
   assign rsp_pos_x        = rsp_pos_ff[0];
   assign rsp_pos_y        = rsp_pos_ff[1];
   assign rsp_pos_z        = rsp_pos_ff[2];
   assign rsp_vertex_color = rsp_vertex_color_ff;
   assign rsp_last_vertex  = rsp_last_vertex_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;

   a_frame_end_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_end_ff |-> rsp_last_vertex_ff)
      else $error("frame end away from the last vertex");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_vertex_ff |-> rsp_vertex_index_ff == VTX_LAST)
      else $error("last vertex flag on wrong index");

   a_next_vertex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !rsp_last_vertex_ff |=>
         rsp_valid_ff && rsp_vertex_index_ff == 3'($past(rsp_vertex_index_ff) + 3'd1))
      else $error("vertex sequence broken");

endmodule

// File: rtl/core/ray_arrow_vertex_expander_top.sv
// ============================================================================
// ray_arrow_vertex_expander_top
// Expands each debug ray into seven camera-facing arrow vertices.
// ============================================================================
// Each request (origin, direction, colour, last flag) becomes seven vertices:
// shaft quad corners 0-3 and head triangle 4-6, positions in saturated signed
// Q16.16 with the request's own colour. A front stage classifies the request
// and parks it in a two-entry queue; the back sequencer works one ray at a
// time through a shared multiplier, a one-bit-per-cycle square root and three
// restoring divider lanes, then hands the arrow to the emitter, which streams
// the vertices while the next ray is computed. For each ray the back
// sequencer takes the square root of the squared camera offset for the
// distance scale, forms the gains and the cross product, then for the cross
// product and for the direction runs a normalising shift, a square root and
// a divide, with the multiply and load steps around them. The camera square
// root is skipped when the camera is 1.5 or more away along an axis, and an
// offset vector that is zero skips its root and divide. Sustained throughput
// is one ray per back-sequencer pass; the emitter sends the seven vertices
// of each ray, pausing while the result side stalls. Write the camera and
// thickness registers only while the block is idle.
module ray_arrow_vertex_expander_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rave_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rave_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rave_pkg::coord_type              req_origin_x,
   input  rave_pkg::coord_type              req_origin_y,
   input  rave_pkg::coord_type              req_origin_z,
   input  rave_pkg::coord_type              req_dir_x,
   input  rave_pkg::coord_type              req_dir_y,
   input  rave_pkg::coord_type              req_dir_z,
   input  logic [31:0]                      req_ray_color,
   input  logic                             req_last_ray,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rave_pkg::VTX_W-1:0]       rsp_vertex_index,
   output rave_pkg::coord_type              rsp_pos_x,
   output rave_pkg::coord_type              rsp_pos_y,
   output rave_pkg::coord_type              rsp_pos_z,
   output logic [31:0]                      rsp_vertex_color,
   output logic                             rsp_last_vertex,
   output logic                             rsp_frame_end
);
   import rave_pkg::*;

   // configuration registers
   coord_type [2:0]    cam_ff, cam_in;
   logic [THICK_W-1:0] thick_ff, thick_in;

   // front to queue
   logic      push_valid;
   logic      push_full;
   ray_type   push_data;
   // queue to back
   logic      pop;
   logic      pop_valid;
   ray_type   pop_data;
   // back to emitter
   logic      arrow_valid;
   logic      arrow_stall;
   arrow_type arrow_data;

   // decode a register write; hold everything else
   always_comb begin
      cam_in   = cam_ff;
      thick_in = thick_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAM_X:     cam_in[0] = csr_wdata;
            CSR_CAM_Y:     cam_in[1] = csr_wdata;
            CSR_CAM_Z:     cam_in[2] = csr_wdata;
            CSR_THICKNESS: thick_in  = csr_wdata[THICK_W-1:0];
            default:       thick_in  = thick_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff   <= '0;
         thick_ff <= THICK_RESET;
      end else begin
         cam_ff   <= cam_in;
         thick_ff <= thick_in;
      end
   end

   // accept and classify
   rave_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cam        (cam_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .org        ({req_origin_z, req_origin_y, req_origin_x}),
      .dir        ({req_dir_z, req_dir_y, req_dir_x}),
      .color      (req_ray_color),
      .last       (req_last_ray),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data)
   );

   // decouple the front from the long arithmetic pass
   rave_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   // side and tip offsets
   rave_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .thickness (thick_ff),
      .q_valid   (pop_valid),
      .q_data    (pop_data),
      .q_pop     (pop),
      .out_valid (arrow_valid),
      .out_stall (arrow_stall),
      .out_data  (arrow_data)
   );

   // stream seven vertices per arrow
   rave_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (arrow_valid),
      .in_stall         (arrow_stall),
      .in_data          (arrow_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_last_vertex  (rsp_last_vertex),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule
